FILE: hw/rtl/scwq_pkg.sv
// types and codes shared by the semaphore wait queue
`timescale 1ns / 1ps
package scwq_pkg;

  localparam int unsigned CFG_BITS    = 16;
  localparam int unsigned REQ_ID_BITS = 8;
  localparam int unsigned STATUS_BITS = 3;
  localparam int unsigned RSP_ID_BITS = 8;
  localparam int unsigned RSP_CNT_BITS = 16;

  typedef enum logic {
    CMD_WAIT   = 1'b0,
    CMD_SIGNAL = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_GRANTED   = 3'd0,
    STAT_BLOCKED   = 3'd1,
    STAT_SIG_NONE  = 3'd2,
    STAT_SIG_WOKE  = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_SATURATED = 3'd5
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_WAKE = 1'b1
  } fsm_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

FILE: hw/rtl/scwq_if.sv
// request, response and configuration channel interfaces
`timescale 1ns / 1ps
interface scwq_req_if;
  import scwq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   command;
  logic [REQ_ID_BITS-1:0] requester_id;
  modport source (output valid, command, requester_id, input ready);
  modport sink (input valid, command, requester_id, output ready);
endinterface

interface scwq_rsp_if;
  import scwq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [STATUS_BITS-1:0]  status;
  logic [RSP_ID_BITS-1:0]  woken_id;
  logic [RSP_CNT_BITS-1:0] count_now;
  modport source (output valid, status, woken_id, count_now, input ready);
  modport sink (input valid, status, woken_id, count_now, output ready);
endinterface

interface scwq_cfg_if;
  import scwq_pkg::*;
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] initial_count;
  modport source (output valid, initial_count, input ready);
  modport sink (input valid, initial_count, output ready);
endinterface

FILE: hw/rtl/scwq_waitq.sv
// circular queue of blocked requester ids in a synchronous memory
`timescale 1ns / 1ps
module scwq_waitq #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  scwq_pkg::q_op_t      op,
  input  logic [ID_BITS-1:0]   push_id,
  output scwq_pkg::q_stat_t    stat,
  output logic [ID_BITS-1:0]   rd_id
);
  import scwq_pkg::*;

  localparam int unsigned PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [ID_BITS-1:0]   mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  head;
  logic [PTR_BITS-1:0]  head_next;
  logic [PTR_BITS-1:0]  tail;
  logic [PTR_BITS-1:0]  tail_next;
  logic [FILL_BITS-1:0] fill;
  logic [FILL_BITS-1:0] fill_next;

  assign stat.empty = (fill == '0);
  assign stat.full  = (fill == FILL_BITS'(QUEUE_DEPTH));

  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    if (op.push) begin
      tail_next = (tail == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : tail + PTR_BITS'(1);
      fill_next = fill + FILL_BITS'(1);
    end
    if (op.pop) begin
      head_next = (head == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_BITS'(1);
      fill_next = fill - FILL_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (op.push) begin
      mem[tail] <= push_id;
    end
    if (op.pop) begin
      rd_id <= mem[head];
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(op.push && op.pop))
    else $error("waitq push and pop in one cycle");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    op.push |-> !stat.full)
    else $error("waitq push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    op.pop |-> !stat.empty)
    else $error("waitq pop while empty");
  a_pop_fill: assert property (@(posedge clk) disable iff (rst)
    op.pop |=> fill == $past(fill) - FILL_BITS'(1))
    else $error("waitq fill not decremented on pop");
`endif

endmodule

FILE: hw/rtl/counting_semaphore_wait_queue.sv
// counting semaphore with a fifo of blocked requesters
//
//  channel  dir  payload                              transfer when
//  req      in   command, requester_id                valid && ready
//  rsp      out  status, woken_id, count_now          valid && ready
//  cfg      in   initial_count                        valid && ready (ready always high)
//
//  a request is handled in the idle state; a signal that wakes a waiter also
//  passes through the wake state, set by the registered read of the waiter memory
//  rsp is a registered output; a new request is taken while a result is
//  being transferred out
//  reset clears count, queue pointers and fill; no memory clearing pass
//  a stalled rsp holds the request side until the result register frees
`timescale 1ns / 1ps
module counting_semaphore_wait_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8,
  parameter int unsigned COUNT_BITS  = 16
) (
  input logic       clk,
  input logic       rst,
  scwq_req_if.sink  req,
  scwq_rsp_if.source rsp,
  scwq_cfg_if.sink  cfg
);
  import scwq_pkg::*;

  fsm_t                     state;
  fsm_t                     state_next;
  logic [COUNT_BITS-1:0]    count;
  logic [COUNT_BITS-1:0]    count_next;
  q_op_t                    q_op;
  q_stat_t                  q_stat;
  logic [ID_BITS-1:0]       rd_id;
  logic                     accept;
  logic                     wake_go;
  logic                     load;
  status_t                  load_status;
  logic                     rsp_valid;
  status_t                  rsp_status;
  logic [RSP_ID_BITS-1:0]   rsp_woken;
  logic [RSP_CNT_BITS-1:0]  rsp_count;

  scwq_waitq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_waitq (
    .clk     (clk),
    .rst     (rst),
    .op      (q_op),
    .push_id (ID_BITS'(req.requester_id)),
    .stat    (q_stat),
    .rd_id   (rd_id)
  );

  assign cfg.ready = 1'b1;
  assign req.ready = (state == FSM_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign wake_go   = (req.command == CMD_SIGNAL) && (count != '1) && !q_stat.empty;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE: begin
        if (accept && wake_go) begin
          state_next = FSM_WAKE;
        end
      end
      FSM_WAKE: state_next = FSM_IDLE;
      default:  state_next = FSM_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_op        = '0;
    count_next  = count;
    load        = 1'b0;
    load_status = STAT_GRANTED;
    case (state)
      FSM_IDLE: begin
        if (accept) begin
          if (req.command == CMD_WAIT) begin
            load = 1'b1;
            if (count != '0) begin
              count_next  = count - COUNT_BITS'(1);
              load_status = STAT_GRANTED;
            end else if (q_stat.full) begin
              load_status = STAT_FULL;
            end else begin
              q_op.push   = 1'b1;
              load_status = STAT_BLOCKED;
            end
          end else begin
            if (count == '1) begin
              load        = 1'b1;
              load_status = STAT_SATURATED;
            end else begin
              count_next = count + COUNT_BITS'(1);
              if (q_stat.empty) begin
                load        = 1'b1;
                load_status = STAT_SIG_NONE;
              end else begin
                q_op.pop = 1'b1;
              end
            end
          end
        end
      end
      FSM_WAKE: begin
        load        = 1'b1;
        load_status = STAT_SIG_WOKE;
      end
      default: begin
        load = 1'b0;
      end
    endcase
    if (cfg.valid && cfg.ready) begin
      count_next = COUNT_BITS'(cfg.initial_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_status <= load_status;
      rsp_woken  <= (state == FSM_WAKE) ? RSP_ID_BITS'(rd_id) : '0;
      rsp_count  <= RSP_CNT_BITS'(count_next);
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.status    = rsp_status;
  assign rsp.woken_id  = rsp_woken;
  assign rsp.count_now = rsp_count;

`ifndef NO_ASSERTIONS
  a_wake_out_free: assert property (@(posedge clk) disable iff (rst)
    state == FSM_WAKE |-> !rsp_valid)
    else $error("result register busy during wake");
  a_wake_no_req: assert property (@(posedge clk) disable iff (rst)
    state == FSM_WAKE |-> !req.ready)
    else $error("request taken during wake");
  a_wake_done: assert property (@(posedge clk) disable iff (rst)
    state == FSM_WAKE |=> state == FSM_IDLE && rsp_valid && rsp_status == STAT_SIG_WOKE)
    else $error("wake did not produce a woken result");
`endif

endmodule
